// ----- src/spq_pkg.sv -----
// Package for the sorted priority queue: word types, codes and control/status bundles.
package spq_pkg;

  localparam int TAG_W  = 16;
  localparam int PRIO_W = 8;

  // Command codes carried in the cmd field of an input word.
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [TAG_W-1:0]  task_tag;
    logic [PRIO_W-1:0] prio;
  } in_word_t;

  typedef struct packed {
    logic [TAG_W-1:0] front_tag;
    logic             queue_empty;
    logic             overflow;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;  // capture the accepted input word
    logic exec;       // apply the captured command and register the result
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } spq_status_t;

endpackage

// ----- src/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: controller, datapath and checks.
//
// Usage: every input word is a command. An enqueue (cmd = 0) carries a task
// tag and a priority; the entry is placed ahead of all stored entries of
// lower or equal priority, so within one priority the newest is served first.
// A dequeue (cmd = 1) removes the front entry and is harmless on an empty queue.
// An enqueue to a full queue is dropped and reported through the overflow bit.
// Every command returns exactly one result word: the front tag (zero when
// empty), the empty flag and the overflow flag, all as seen after the command.
// Timing: a word accepted at one edge is executed in the following cycle, and
// its result is then registered and offered on out_valid. No new word is
// accepted while a command is being executed; the rate is set by the
// controller's accept/execute sequence. All entry cells compare against the
// new priority and shift together, whatever DEPTH is.
// Reset empties the queue at once; entry contents are not cleared. When the
// receiver stalls, the result word is held in its register and in_ready stays
// low until that word has been taken.
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spq_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spq_pkg::out_word_t out_data
);

  spq_pkg::spq_cmd_t    cmd;
  spq_pkg::spq_status_t sts;

  // The controller sequences accept and execute and owns the output valid flag.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the sorted cells and the registered result word.
  spq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // A waiting result must block new words, otherwise it would be overwritten.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while a result word is stalled");

  // Every accepted word yields its result after the execute state.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##2 out_valid)
    else $error("result word missing after an accepted command");

  // Overflow is reported only when the queue really is full.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid) && out_data.overflow) |-> sts.full)
    else $error("overflow flagged on a queue that is not full");

  // The empty flag agrees with the datapath's occupancy once a result is shown.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_data.queue_empty == sts.empty))
    else $error("empty flag disagrees with queue occupancy");

endmodule

// ----- src/spq_ctrl.sv -----
// Controller state machine of the sorted priority queue.
module spq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  spq_pkg::spq_status_t sts,
  output spq_pkg::spq_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  // A new word is taken only when the result register is free or is emptied this cycle.
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load_item = accept;
    cmd.exec      = (state_r == ST_EXEC) && !sts.full | (state_r == ST_EXEC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/spq_dp.sv -----
// Datapath of the sorted priority queue: entry cells, occupancy count and result register.
module spq_dp #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spq_pkg::in_word_t    in_data,
  input  spq_pkg::spq_cmd_t    cmd,
  output spq_pkg::spq_status_t sts,
  output spq_pkg::out_word_t   out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [spq_pkg::TAG_W-1:0]  tags_r  [DEPTH];
  logic [spq_pkg::PRIO_W-1:0] prios_r [DEPTH];
  logic [spq_pkg::TAG_W-1:0]  tags_nxt  [DEPTH];
  logic [spq_pkg::PRIO_W-1:0] prios_nxt [DEPTH];
  logic [DEPTH-1:0]           ahead;
  logic [CNT_W-1:0]           count_r, count_nxt;
  spq_pkg::in_word_t          item_r;
  spq_pkg::out_word_t         res_r, res_nxt;
  logic                       full, do_enq, do_deq, is_enq;
  logic [spq_pkg::TAG_W-1:0]  front_nxt;

  assign full   = (count_r == CNT_W'(DEPTH));
  assign is_enq = (item_r.cmd == spq_pkg::CMD_ENQ);
  assign do_enq = cmd.exec && is_enq && !full;
  assign do_deq = cmd.exec && !is_enq && (count_r != '0);

  // Entries that stay ahead of a new word form a prefix, since the cells are sorted.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ahead[i] = (CNT_W'(i) < count_r) && (prios_r[i] > item_r.prio);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_comb begin
      tags_nxt[g]  = tags_r[g];
      prios_nxt[g] = prios_r[g];
      if (do_enq && !ahead[g]) begin
        if (g == 0) begin
          tags_nxt[g]  = item_r.task_tag;
          prios_nxt[g] = item_r.prio;
        end else if (ahead[(g > 0) ? g - 1 : 0]) begin
          tags_nxt[g]  = item_r.task_tag;
          prios_nxt[g] = item_r.prio;
        end else begin
          tags_nxt[g]  = tags_r[(g > 0) ? g - 1 : 0];
          prios_nxt[g] = prios_r[(g > 0) ? g - 1 : 0];
        end
      end else if (do_deq && (g < DEPTH - 1)) begin
        tags_nxt[g]  = tags_r[(g < DEPTH - 1) ? g + 1 : g];
        prios_nxt[g] = prios_r[(g < DEPTH - 1) ? g + 1 : g];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
    front_nxt             = tags_nxt[0];
    res_nxt.queue_empty   = (count_nxt == '0);
    res_nxt.front_tag     = res_nxt.queue_empty ? '0 : front_nxt;
    res_nxt.overflow      = is_enq && full;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      tags_r[i]  <= tags_nxt[i];
      prios_r[i] <= prios_nxt[i];
    end
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign sts.full  = full;
  assign sts.empty = (count_r == '0);
  assign out_data  = res_r;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the sorted priority queue, with a clocked driver and monitor.
module tb_top;

  localparam int DEPTH       = 16;
  localparam int RAND_WORDS  = 1750;
  localparam int CYCLE_LIMIT = 200000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  spq_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  spq_pkg::out_word_t out_data;

  sorted_priority_queue #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Command words still to be offered, and the result words that the
  // accepted commands are due to produce, oldest first.
  spq_pkg::in_word_t  cmd_words[$];
  spq_pkg::out_word_t front_words_due[$];

  // The testbench's own picture of the queue contents. Entry 0 is the front.
  logic [spq_pkg::TAG_W-1:0]  model_tags[DEPTH];
  logic [spq_pkg::PRIO_W-1:0] model_prios[DEPTH];
  int                         model_count = 0;

  int   n_total    = 0;
  int   n_sent     = 0;
  int   n_accepted = 0;
  int   n_errors   = 0;
  int   cycle_cnt  = 0;
  int   send_idle  = 0;
  int   recv_idle  = 0;
  bit   word_taken = 1'b0;

  // Applies one command to the model and returns the result word it should
  // give. A new entry goes ahead of every stored entry whose priority is not
  // higher than its own, so within one priority the newest is served first.
  function automatic spq_pkg::out_word_t apply_command(spq_pkg::in_word_t w);
    spq_pkg::out_word_t r;
    int                 pos;
    r = '0;
    if (w.cmd == spq_pkg::CMD_ENQ) begin
      if (model_count >= DEPTH) begin
        // A full queue drops the word and leaves the contents untouched.
        r.overflow = 1'b1;
      end else begin
        pos = 0;
        while (pos < model_count && model_prios[pos] > w.prio) pos++;
        for (int k = model_count; k > pos; k--) begin
          model_tags[k]  = model_tags[k-1];
          model_prios[k] = model_prios[k-1];
        end
        model_tags[pos]  = w.task_tag;
        model_prios[pos] = w.prio;
        model_count++;
      end
    end else if (model_count > 0) begin
      // A dequeue on an empty queue changes nothing.
      for (int k = 1; k < model_count; k++) begin
        model_tags[k-1]  = model_tags[k];
        model_prios[k-1] = model_prios[k];
      end
      model_count--;
    end
    if (model_count > 0) begin
      r.front_tag = model_tags[0];
    end else begin
      r.queue_empty = 1'b1;
    end
    return r;
  endfunction

  task automatic add_word(input logic c, input logic [spq_pkg::TAG_W-1:0] t,
                          input logic [spq_pkg::PRIO_W-1:0] p);
    spq_pkg::in_word_t w;
    w.cmd      = c;
    w.task_tag = t;
    w.prio     = p;
    cmd_words.push_back(w);
  endtask

  // Driver: everything changes on the falling edge. The idling rates follow
  // the progress through the stimulus: first the sender idles less than the
  // receiver, then the other way round, and in the last third neither idles.
  always @(negedge clk) begin
    if (rst_n) begin
      if (n_sent * 3 < n_total) begin
        send_idle = 29;
        recv_idle = 60;
      end else if (n_sent * 3 < 2 * n_total) begin
        send_idle = 60;
        recv_idle = 29;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      // A word on offer is held, unchanged, until the monitor has seen it taken.
      if (!in_valid || word_taken) begin
        word_taken = 1'b0;
        if (cmd_words.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_data  <= cmd_words.pop_front();
          n_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Monitor: samples both channels on the rising edge. An accepted command
  // is run through the model at once, so the expected word is queued before
  // any result can appear.
  always @(posedge clk) begin
    spq_pkg::out_word_t due;
    cycle_cnt++;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        front_words_due.push_back(apply_command(in_data));
        word_taken = 1'b1;
        n_accepted++;
      end
      if (out_valid && out_ready) begin
        if (front_words_due.size() == 0) begin
          $display("%0t: result word with none due: front_tag %h empty %b overflow %b",
                   $time, out_data.front_tag, out_data.queue_empty, out_data.overflow);
          n_errors++;
        end else begin
          due = front_words_due.pop_front();
          if (out_data.front_tag !== due.front_tag ||
              out_data.queue_empty !== due.queue_empty ||
              out_data.overflow !== due.overflow) begin
            $display("%0t: mismatch, expected front_tag %h empty %b overflow %b,",
                     $time, due.front_tag, due.queue_empty, due.overflow);
            $display("%0t:   actual front_tag %h empty %b overflow %b",
                     $time, out_data.front_tag, out_data.queue_empty, out_data.overflow);
            n_errors++;
          end
        end
      end
    end
  end

  // Watchdog on the cycle counter.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    int          burst_len;
    int          enq_pct;
    bit          narrow;
    logic [7:0]  base_prio;
    logic [7:0]  pr;

    // Directed part: a dequeue on the empty queue, the extremes of tag and
    // priority, ties at the front and at the back, a fill to the brim and
    // two enqueues that must be dropped.
    add_word(spq_pkg::CMD_DEQ, 16'h0000, 8'h00);
    add_word(spq_pkg::CMD_ENQ, 16'hFFFF, 8'hFF);
    add_word(spq_pkg::CMD_ENQ, 16'h0000, 8'h00);
    add_word(spq_pkg::CMD_ENQ, 16'h1234, 8'hFF);
    add_word(spq_pkg::CMD_ENQ, 16'h00AA, 8'h00);
    add_word(spq_pkg::CMD_ENQ, 16'h5555, 8'h80);
    add_word(spq_pkg::CMD_ENQ, 16'hAAAA, 8'hFE);
    for (int i = 0; i < DEPTH - 6; i++) begin
      add_word(spq_pkg::CMD_ENQ, 16'h0100 + 16'(i), 8'($urandom));
    end
    add_word(spq_pkg::CMD_ENQ, 16'hBEEF, 8'hFF);
    add_word(spq_pkg::CMD_ENQ, 16'h7777, 8'h00);
    add_word(spq_pkg::CMD_DEQ, 16'hFFFF, 8'hFF);
    add_word(spq_pkg::CMD_DEQ, 16'h0000, 8'h00);

    // Random part in bursts: filling bursts drive the queue up to full and
    // beyond, draining bursts take it down past empty, and mixed bursts wander
    // in between. Half of the bursts keep priorities in a narrow band so that
    // ties are common.
    while (cmd_words.size() < 20 + RAND_WORDS) begin
      burst_len = $urandom_range(24, 4);
      case ($urandom_range(2))
        0:       enq_pct = 85;
        1:       enq_pct = 20;
        default: enq_pct = 50;
      endcase
      narrow    = $urandom_range(1);
      base_prio = 8'($urandom);
      repeat (burst_len) begin
        pr = narrow ? 8'(base_prio + 8'($urandom_range(2))) : 8'($urandom);
        add_word(($urandom_range(99) < enq_pct) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ,
                 16'($urandom), pr);
      end
    end
    n_total = cmd_words.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total || front_words_due.size() != 0) @(posedge clk);
    // Run on to catch any stray result word.
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_dp.sv
src/sorted_priority_queue.sv
test/tb_top.sv
